@@ hdl/csi_me_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSI motion estimator package
// Shared types, sizes and constants of the motion estimator.
// ----------------------------------------------------------------------------
package csi_me_pkg;

	localparam int WINDOW_LEN = 50;
	localparam int MAX_PAIRS = 512;

	localparam int WIN_W = $clog2(WINDOW_LEN + 1);
	localparam int ADDR_W = $clog2(WINDOW_LEN);
	localparam int MAG_W = 16 + WIN_W;
	localparam int S1_W = MAG_W + 1;
	localparam int S2_W = 32 + WIN_W;
	localparam int NUM_W = 2 * MAG_W;

	localparam int PAIR_W = $clog2(MAX_PAIRS + 1);
	localparam int AMP_ACC_W = 16 + PAIR_W;
	localparam int SINE_ACC_W = 17 + PAIR_W;

	localparam int DIV_NW = (NUM_W > 48) ? NUM_W : 48;
	localparam int DIV_DW = 32;
	localparam int DIV_CW = $clog2(DIV_NW + 1);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

	localparam logic [31:0] AMP_CEIL_INIT = 32'd66;
	localparam logic [31:0] PHASE_CEIL_INIT = 32'd1073742;
	localparam logic [31:0] AMP_THRESH = 32'd7;
	localparam logic [31:0] PHASE_THRESH = 32'd107375;
	localparam logic [12:0] RATE_DOWN = 13'd6554;
	localparam logic [12:0] RATE_UP = 13'd131;
	localparam logic [8:0] RATE_CEIL = 9'd328;
	localparam logic [15:0] W_AMP = 16'd39322;
	localparam logic [15:0] W_PHASE = 16'd26214;
	localparam logic [16:0] SCORE_ONE = 17'd65536;
	localparam logic [15:0] SINE_MAX = 16'd32767;

	typedef struct packed {
		logic kind;
		logic signed [7:0] i_value;
		logic signed [7:0] q_value;
		logic last_pair;
		logic signed [7:0] frame_rssi;
	} in_t;

	typedef struct packed {
		logic [16:0] motion;
		logic [16:0] amp_motion;
		logic [16:0] phase_motion;
		logic signed [7:0] rssi_out;
		logic [31:0] frames_seen;
	} out_t;

	typedef struct packed {
		logic rst;
		logic [15:0] amp;
		logic [15:0] sine;
		logic signed [7:0] rssi;
	} frame_t;

	typedef struct packed {
		logic start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DIV_NW-1:0] quot;
	} div_resp_t;

endpackage

@@ hdl/csi_me_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSI motion estimator divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module csi_me_div (
	input logic clk,
	input logic arst_n,
	input csi_me_pkg::div_req_t req,
	output csi_me_pkg::div_resp_t resp
);

	logic [csi_me_pkg::DIV_DW-1:0] den_q;
	logic [csi_me_pkg::DIV_DW-1:0] rem_q;
	logic [csi_me_pkg::DIV_NW-1:0] quo_q;
	logic [csi_me_pkg::DIV_CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [csi_me_pkg::DIV_DW:0] trial;
	logic [csi_me_pkg::DIV_DW:0] diff;
	logic ge;

	assign trial = {rem_q, quo_q[csi_me_pkg::DIV_NW-1]};
	assign ge = trial >= {1'b0, den_q};
	assign diff = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == csi_me_pkg::DIV_CW'(csi_me_pkg::DIV_NW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			rem_q <= ge ? diff[csi_me_pkg::DIV_DW-1:0] : trial[csi_me_pkg::DIV_DW-1:0];
			quo_q <= {quo_q[csi_me_pkg::DIV_NW-2:0], ge};
		end else if (req.start) begin
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= req.num;
		end
	end

	assign resp.done = done_q;
	assign resp.quot = quo_q;

endmodule

@@ hdl/csi_me_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSI motion estimator frame queue
// Short queue of frame summaries between the front and the back end.
// ----------------------------------------------------------------------------
module csi_me_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input csi_me_pkg::frame_t wdata,
	output logic empty,
	input logic pop,
	output csi_me_pkg::frame_t rdata
);

	csi_me_pkg::frame_t mem [csi_me_pkg::FIFO_DEPTH];
	logic [csi_me_pkg::FIFO_AW-1:0] wr_q;
	logic [csi_me_pkg::FIFO_AW-1:0] rd_q;
	logic [csi_me_pkg::FIFO_CW-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = cnt_q == csi_me_pkg::FIFO_CW'(csi_me_pkg::FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == csi_me_pkg::FIFO_AW'(csi_me_pkg::FIFO_DEPTH - 1)) ?
					'0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == csi_me_pkg::FIFO_AW'(csi_me_pkg::FIFO_DEPTH - 1)) ?
					'0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= wdata;
		end
	end

endmodule

@@ hdl/csi_me_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSI motion estimator front end
// Takes words, finds pair amplitude and sine, forms frame means and passes reset words on.
// ----------------------------------------------------------------------------
module csi_me_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input csi_me_pkg::in_t in_word,
	output csi_me_pkg::div_req_t div_req,
	input csi_me_pkg::div_resp_t div_resp,
	output logic q_push,
	input logic q_full,
	output csi_me_pkg::frame_t q_word
);

	typedef enum logic [7:0] {
		F_IDLE = 8'b0000_0001,
		F_SQRT = 8'b0000_0010,
		F_ACC = 8'b0000_0100,
		F_SDIV = 8'b0000_1000,
		F_END = 8'b0001_0000,
		F_MAMP = 8'b0010_0000,
		F_MSIN = 8'b0100_0000,
		F_PUSH = 8'b1000_0000
	} fstate_t;

	fstate_t state_q;
	logic [csi_me_pkg::PAIR_W-1:0] pair_cnt_q;
	logic [csi_me_pkg::PAIR_W-1:0] nz_cnt_q;
	logic [csi_me_pkg::AMP_ACC_W-1:0] amp_acc_q;
	logic signed [csi_me_pkg::SINE_ACC_W-1:0] sine_acc_q;
	logic rst_q;
	logic last_q;
	logic signed [7:0] rssi_q;
	logic signed [7:0] qv_q;
	logic [31:0] v_q;
	logic [31:0] r_q;
	logic [31:0] bit_q;
	logic [15:0] mean_amp_q;
	logic [15:0] mean_sine_q;

	logic signed [15:0] i_sq;
	logic signed [15:0] q_sq;
	logic [15:0] sq;
	logic [31:0] trial;
	logic ge;
	logic [15:0] amp;
	logic [7:0] mq;
	logic [15:0] mag;
	logic [csi_me_pkg::SINE_ACC_W-1:0] sine_abs;
	logic accept;

	assign accept = push && !full;
	assign full = state_q != F_IDLE;
	assign i_sq = in_word.i_value * in_word.i_value;
	assign q_sq = in_word.q_value * in_word.q_value;
	assign sq = $unsigned(i_sq) + $unsigned(q_sq);
	assign trial = r_q + bit_q;
	assign ge = v_q >= trial;
	assign amp = r_q[15:0];
	assign mq = qv_q[7] ? 8'(-qv_q) : 8'(qv_q);
	assign mag = (!qv_q[7] && div_resp.quot > csi_me_pkg::DIV_NW'(csi_me_pkg::SINE_MAX)) ?
		csi_me_pkg::SINE_MAX : div_resp.quot[15:0];
	assign sine_abs = sine_acc_q[csi_me_pkg::SINE_ACC_W-1] ?
		csi_me_pkg::SINE_ACC_W'(-sine_acc_q) : csi_me_pkg::SINE_ACC_W'(sine_acc_q);

	always_comb begin
		div_req.start = 1'b0;
		div_req.num = '0;
		div_req.den = '0;
		case (state_q)
			F_ACC: begin
				div_req.start = amp != '0;
				div_req.num = csi_me_pkg::DIV_NW'({mq, 23'b0});
				div_req.den = csi_me_pkg::DIV_DW'(amp);
			end
			F_END: begin
				div_req.start = pair_cnt_q >= csi_me_pkg::PAIR_W'(2);
				div_req.num = csi_me_pkg::DIV_NW'(amp_acc_q);
				div_req.den = csi_me_pkg::DIV_DW'(pair_cnt_q);
			end
			F_MAMP: begin
				div_req.start = div_resp.done && (nz_cnt_q != '0);
				div_req.num = csi_me_pkg::DIV_NW'(sine_abs);
				div_req.den = csi_me_pkg::DIV_DW'(nz_cnt_q);
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	assign q_push = state_q == F_PUSH;
	assign q_word.rst = rst_q;
	assign q_word.amp = mean_amp_q;
	assign q_word.sine = mean_sine_q;
	assign q_word.rssi = rssi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			pair_cnt_q <= '0;
			nz_cnt_q <= '0;
			amp_acc_q <= '0;
			sine_acc_q <= '0;
			rst_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						rst_q <= in_word.kind;
						last_q <= in_word.last_pair;
						if (in_word.kind) begin
							state_q <= F_PUSH;
						end else if (pair_cnt_q <
								csi_me_pkg::PAIR_W'(csi_me_pkg::MAX_PAIRS)) begin
							state_q <= F_SQRT;
						end else if (in_word.last_pair) begin
							state_q <= F_END;
						end
					end
				end
				F_SQRT: begin
					if (bit_q[0]) begin
						state_q <= F_ACC;
					end
				end
				F_ACC: begin
					pair_cnt_q <= pair_cnt_q + 1'b1;
					amp_acc_q <= amp_acc_q + csi_me_pkg::AMP_ACC_W'(amp);
					if (amp != '0) begin
						state_q <= F_SDIV;
					end else begin
						state_q <= last_q ? F_END : F_IDLE;
					end
				end
				F_SDIV: begin
					if (div_resp.done) begin
						nz_cnt_q <= nz_cnt_q + 1'b1;
						sine_acc_q <= qv_q[7] ?
							sine_acc_q - csi_me_pkg::SINE_ACC_W'(mag) :
							sine_acc_q + csi_me_pkg::SINE_ACC_W'(mag);
						state_q <= last_q ? F_END : F_IDLE;
					end
				end
				F_END: begin
					if (pair_cnt_q < csi_me_pkg::PAIR_W'(2)) begin
						pair_cnt_q <= '0;
						nz_cnt_q <= '0;
						amp_acc_q <= '0;
						sine_acc_q <= '0;
						state_q <= F_IDLE;
					end else begin
						state_q <= F_MAMP;
					end
				end
				F_MAMP: begin
					if (div_resp.done) begin
						state_q <= (nz_cnt_q != '0) ? F_MSIN : F_PUSH;
					end
				end
				F_MSIN: begin
					if (div_resp.done) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						if (!rst_q) begin
							pair_cnt_q <= '0;
							nz_cnt_q <= '0;
							amp_acc_q <= '0;
							sine_acc_q <= '0;
						end
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && accept) begin
			rssi_q <= in_word.frame_rssi;
			qv_q <= in_word.q_value;
			v_q <= {sq, 16'b0};
			r_q <= '0;
			bit_q <= 32'h4000_0000;
		end
		if (state_q == F_SQRT) begin
			if (ge) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (state_q == F_MAMP && div_resp.done) begin
			mean_amp_q <= div_resp.quot[15:0];
			mean_sine_q <= '0;
		end
		if (state_q == F_MSIN && div_resp.done) begin
			mean_sine_q <= sine_acc_q[csi_me_pkg::SINE_ACC_W-1] ?
				16'(-div_resp.quot[15:0]) : div_resp.quot[15:0];
		end
	end

endmodule

@@ hdl/csi_me_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSI motion estimator back end
// Keeps the window, computes variances, tracks them and scores motion.
// ----------------------------------------------------------------------------
module csi_me_back (
	input logic clk,
	input logic arst_n,
	input logic q_empty,
	output logic q_pop,
	input csi_me_pkg::frame_t q_word,
	output csi_me_pkg::div_req_t div_req,
	input csi_me_pkg::div_resp_t div_resp,
	output logic empty,
	input logic pop,
	output csi_me_pkg::out_t out_word
);

	typedef enum logic [10:0] {
		B_IDLE = 11'b000_0000_0001,
		B_SWEEP = 11'b000_0000_0010,
		B_VMUL = 11'b000_0000_0100,
		B_VSUB = 11'b000_0000_1000,
		B_VDIV = 11'b000_0001_0000,
		B_TRK1 = 11'b000_0010_0000,
		B_TRK2 = 11'b000_0100_0000,
		B_TRK3 = 11'b000_1000_0000,
		B_SDIV = 11'b001_0000_0000,
		B_BLEND1 = 11'b010_0000_0000,
		B_BLEND2 = 11'b100_0000_0000
	} bstate_t;

	bstate_t state_q;
	logic ch_q;
	logic [csi_me_pkg::ADDR_W-1:0] pos_q;
	logic [csi_me_pkg::WIN_W-1:0] fill_q;
	logic [csi_me_pkg::WIN_W-1:0] k_q;
	logic [15:0] amp_mem [csi_me_pkg::WINDOW_LEN];
	logic [15:0] ph_mem [csi_me_pkg::WINDOW_LEN];
	logic [15:0] amp_rd_s1;
	logic [15:0] ph_rd_s1;
	logic v_s1;
	logic v_s2;
	logic signed [16:0] xa_s2;
	logic signed [16:0] xp_s2;
	logic [31:0] sqa_s2;
	logic [31:0] sqp_s2;
	logic signed [csi_me_pkg::S1_W-1:0] s1a_q;
	logic signed [csi_me_pkg::S1_W-1:0] s1p_q;
	logic [csi_me_pkg::S2_W-1:0] s2a_q;
	logic [csi_me_pkg::S2_W-1:0] s2p_q;
	logic [csi_me_pkg::NUM_W-1:0] mm_q;
	logic [csi_me_pkg::NUM_W-1:0] ns_q;
	logic [2*csi_me_pkg::WIN_W-1:0] nn_q;
	logic [31:0] var_q;
	logic [31:0] afl_q;
	logic [31:0] ace_q;
	logic [31:0] pfl_q;
	logic [31:0] pce_q;
	logic [44:0] prf_q;
	logic [40:0] prc_q;
	logic [16:0] am_q;
	logic [16:0] pm_q;
	logic [32:0] pa_q;
	logic [32:0] pp_q;
	logic [31:0] frames_q;
	logic signed [7:0] rssi_q;
	logic out_valid_q;
	csi_me_pkg::out_t out_q;

	logic rd_en;
	logic mem_we;
	logic signed [15:0] ph_x;
	logic signed [31:0] ph_sq;
	logic [31:0] amp_sq;
	logic signed [csi_me_pkg::S1_W-1:0] s1_sel;
	logic [csi_me_pkg::S2_W-1:0] s2_sel;
	logic [csi_me_pkg::MAG_W-1:0] m;
	logic [csi_me_pkg::NUM_W-1:0] vnum;
	logic [31:0] fl;
	logic [31:0] ce;
	logic [31:0] thr;
	logic [31:0] df;
	logic [12:0] ratef;
	logic [31:0] dc;
	logic [31:0] stepf;
	logic [31:0] stepc;
	logic [31:0] fl_new;
	logic [31:0] ce_new;
	logic score_zero;
	logic [47:0] snum;
	logic [16:0] score;
	logic [33:0] msum;

	assign q_pop = (state_q == B_IDLE) && !q_empty;
	assign mem_we = q_pop && !q_word.rst;
	assign rd_en = (state_q == B_SWEEP) && (k_q < fill_q);

	assign ph_x = ph_rd_s1;
	assign ph_sq = ph_x * ph_x;
	assign amp_sq = amp_rd_s1 * amp_rd_s1;

	assign s1_sel = ch_q ? s1p_q : s1a_q;
	assign s2_sel = ch_q ? s2p_q : s2a_q;
	assign m = s1_sel[csi_me_pkg::S1_W-1] ?
		csi_me_pkg::MAG_W'(-s1_sel) : csi_me_pkg::MAG_W'(s1_sel);
	assign vnum = ns_q - mm_q;

	assign fl = ch_q ? pfl_q : afl_q;
	assign ce = ch_q ? pce_q : ace_q;
	assign thr = ch_q ? csi_me_pkg::PHASE_THRESH : csi_me_pkg::AMP_THRESH;
	assign df = (var_q < fl) ? fl - var_q : var_q - fl;
	assign ratef = (var_q < fl) ? csi_me_pkg::RATE_DOWN : csi_me_pkg::RATE_UP;
	assign dc = ce - var_q;
	assign stepf = 32'(prf_q[44:16]);
	assign stepc = 32'(prc_q[40:16]);
	assign fl_new = (fl < thr) ? var_q : ((var_q < fl) ? fl - stepf : fl + stepf);
	assign ce_new = (var_q > ce) ? var_q : ce - stepc;
	assign score_zero = (ce <= fl) || ((ce - fl) < thr) || (var_q <= fl);
	assign snum = {var_q - fl, 16'b0};
	assign score = (div_resp.quot > csi_me_pkg::DIV_NW'(csi_me_pkg::SCORE_ONE)) ?
		csi_me_pkg::SCORE_ONE : div_resp.quot[16:0];
	assign msum = 34'(pa_q) + 34'(pp_q) + 34'(32768);

	always_comb begin
		div_req.start = 1'b0;
		div_req.num = '0;
		div_req.den = '0;
		case (state_q)
			B_VSUB: begin
				div_req.start = 1'b1;
				div_req.num = csi_me_pkg::DIV_NW'(vnum);
				div_req.den = csi_me_pkg::DIV_DW'(nn_q);
			end
			B_TRK3: begin
				div_req.start = !score_zero;
				div_req.num = csi_me_pkg::DIV_NW'(snum);
				div_req.den = ce - fl;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			amp_mem[pos_q] <= q_word.amp;
			ph_mem[pos_q] <= q_word.sine;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			amp_rd_s1 <= amp_mem[k_q[csi_me_pkg::ADDR_W-1:0]];
			ph_rd_s1 <= ph_mem[k_q[csi_me_pkg::ADDR_W-1:0]];
		end
		if (v_s1) begin
			xa_s2 <= {1'b0, amp_rd_s1};
			xp_s2 <= {ph_rd_s1[15], ph_rd_s1};
			sqa_s2 <= amp_sq;
			sqp_s2 <= $unsigned(ph_sq);
		end
		if (state_q == B_VMUL) begin
			mm_q <= m * m;
			ns_q <= fill_q * s2_sel;
			nn_q <= fill_q * fill_q;
		end
		if (state_q == B_VDIV && div_resp.done) begin
			var_q <= div_resp.quot[31:0];
		end
		if (state_q == B_TRK1) begin
			prf_q <= df * ratef;
			prc_q <= dc * csi_me_pkg::RATE_CEIL;
		end
		if (state_q == B_BLEND1) begin
			pa_q <= am_q * csi_me_pkg::W_AMP;
			pp_q <= pm_q * csi_me_pkg::W_PHASE;
		end
		if (state_q == B_BLEND2 && !out_valid_q) begin
			out_q.motion <= msum[32:16];
			out_q.amp_motion <= am_q;
			out_q.phase_motion <= pm_q;
			out_q.rssi_out <= rssi_q;
			out_q.frames_seen <= frames_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			ch_q <= 1'b0;
			pos_q <= '0;
			fill_q <= '0;
			k_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			s1a_q <= '0;
			s1p_q <= '0;
			s2a_q <= '0;
			s2p_q <= '0;
			afl_q <= '0;
			ace_q <= csi_me_pkg::AMP_CEIL_INIT;
			pfl_q <= '0;
			pce_q <= csi_me_pkg::PHASE_CEIL_INIT;
			am_q <= '0;
			pm_q <= '0;
			frames_q <= '0;
			rssi_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
			if (v_s2) begin
				s1a_q <= s1a_q + csi_me_pkg::S1_W'(xa_s2);
				s1p_q <= s1p_q + csi_me_pkg::S1_W'(xp_s2);
				s2a_q <= s2a_q + csi_me_pkg::S2_W'(sqa_s2);
				s2p_q <= s2p_q + csi_me_pkg::S2_W'(sqp_s2);
			end
			if (state_q == B_BLEND2 && !out_valid_q) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (q_pop) begin
						if (q_word.rst) begin
							pos_q <= '0;
							fill_q <= '0;
							afl_q <= '0;
							ace_q <= csi_me_pkg::AMP_CEIL_INIT;
							pfl_q <= '0;
							pce_q <= csi_me_pkg::PHASE_CEIL_INIT;
						end else begin
							pos_q <= (pos_q ==
								csi_me_pkg::ADDR_W'(csi_me_pkg::WINDOW_LEN - 1)) ?
								'0 : pos_q + 1'b1;
							if (fill_q < csi_me_pkg::WIN_W'(csi_me_pkg::WINDOW_LEN)) begin
								fill_q <= fill_q + 1'b1;
							end
							frames_q <= frames_q + 1'b1;
							rssi_q <= q_word.rssi;
							s1a_q <= '0;
							s1p_q <= '0;
							s2a_q <= '0;
							s2p_q <= '0;
							k_q <= '0;
							ch_q <= 1'b0;
							state_q <= B_SWEEP;
						end
					end
				end
				B_SWEEP: begin
					if (rd_en) begin
						k_q <= k_q + 1'b1;
					end else if (!v_s1 && !v_s2) begin
						state_q <= B_VMUL;
					end
				end
				B_VMUL: begin
					state_q <= B_VSUB;
				end
				B_VSUB: begin
					state_q <= B_VDIV;
				end
				B_VDIV: begin
					if (div_resp.done) begin
						state_q <= B_TRK1;
					end
				end
				B_TRK1: begin
					state_q <= B_TRK2;
				end
				B_TRK2: begin
					if (ch_q) begin
						pfl_q <= fl_new;
						pce_q <= ce_new;
					end else begin
						afl_q <= fl_new;
						ace_q <= ce_new;
					end
					state_q <= B_TRK3;
				end
				B_TRK3: begin
					if (score_zero) begin
						if (ch_q) begin
							pm_q <= '0;
							state_q <= B_BLEND1;
						end else begin
							am_q <= '0;
							ch_q <= 1'b1;
							state_q <= B_VMUL;
						end
					end else begin
						state_q <= B_SDIV;
					end
				end
				B_SDIV: begin
					if (div_resp.done) begin
						if (ch_q) begin
							pm_q <= score;
							state_q <= B_BLEND1;
						end else begin
							am_q <= score;
							ch_q <= 1'b1;
							state_q <= B_VMUL;
						end
					end
				end
				B_BLEND1: begin
					state_q <= B_BLEND2;
				end
				B_BLEND2: begin
					if (!out_valid_q) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign empty = !out_valid_q;
	assign out_word = out_q;

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= csi_me_pkg::WIN_W'(csi_me_pkg::WINDOW_LEN))
		else $error("window fill beyond window length");
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= csi_me_pkg::ADDR_W'(csi_me_pkg::WINDOW_LEN - 1))
		else $error("window position out of range");
	a_score_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(am_q <= csi_me_pkg::SCORE_ONE) && (pm_q <= csi_me_pkg::SCORE_ONE))
		else $error("score above one");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_BLEND2 && !out_valid_q) |=> (out_valid_q && state_q == B_IDLE))
		else $error("finished result not presented");
`endif

endmodule

@@ hdl/csi_motion_estimator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSI motion estimator
// Scores motion from the amplitude and phase spread of I/Q frames.
// ----------------------------------------------------------------------------
// Each pair runs a bitwise square root for its amplitude, then a sine divide when it is nonzero.
// A frame end adds up to two divides in the front end before the frame is queued.
// The back end pops a frame, sweeps the window and runs up to two divides per channel;
// a four-entry queue separates the two.
// A result appears in the cycle after the back end finishes and waits for pop.
// Reset clears all control state and trackers; window entries are written before use.
module csi_motion_estimator (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input csi_me_pkg::in_t in_word,
	output logic empty,
	input logic pop,
	output csi_me_pkg::out_t out_word
);

	csi_me_pkg::div_req_t fdiv_req;
	csi_me_pkg::div_resp_t fdiv_resp;
	csi_me_pkg::div_req_t bdiv_req;
	csi_me_pkg::div_resp_t bdiv_resp;
	csi_me_pkg::frame_t fq_wdata;
	csi_me_pkg::frame_t fq_rdata;
	logic fq_push;
	logic fq_full;
	logic fq_pop;
	logic fq_empty;

	csi_me_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_word(in_word),
		.div_req(fdiv_req),
		.div_resp(fdiv_resp),
		.q_push(fq_push),
		.q_full(fq_full),
		.q_word(fq_wdata)
	);

	csi_me_div u_front_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(fdiv_req),
		.resp(fdiv_resp)
	);

	csi_me_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(fq_push),
		.full(fq_full),
		.wdata(fq_wdata),
		.empty(fq_empty),
		.pop(fq_pop),
		.rdata(fq_rdata)
	);

	csi_me_div u_back_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(bdiv_req),
		.resp(bdiv_resp)
	);

	csi_me_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(fq_empty),
		.q_pop(fq_pop),
		.q_word(fq_rdata),
		.div_req(bdiv_req),
		.div_resp(bdiv_resp),
		.empty(empty),
		.pop(pop),
		.out_word(out_word)
	);

endmodule
